// ===== src/fast_corner_arc_response_defines.svh =====
// assertion macros for the corner response rtl
`ifndef FAST_CORNER_ARC_RESPONSE_DEFINES_SVH
`define FAST_CORNER_ARC_RESPONSE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FCAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FCAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fcar_pkg.sv =====
// shared types, constants and helpers for the corner response block
package fcar_pkg;

    localparam int RING_SIZE   = 16;
    localparam int PIX_W       = 8;
    localparam int RESP_W      = 5;
    localparam int THR_W       = 8;
    localparam int ARC_W       = 5;
    localparam int CFG_DATA_W  = 8;
    localparam int LANE_IDX_W  = 4;
    localparam int GROUP_SIZE  = 4;
    localparam int NUM_GROUPS  = RING_SIZE / GROUP_SIZE;
    localparam int COMPASS_STEP = 4;

    localparam logic [THR_W-1:0] THR_RESET        = 8'd20;
    localparam logic [ARC_W-1:0] ARC_RESET        = 5'd12;
    localparam logic [ARC_W-1:0] PRECHECK_MIN_ARC = 5'd12;
    localparam logic [2:0]       PRECHECK_AGREE   = 3'd3;

    typedef enum logic [0:0] {
        CFG_DIFF_THRESHOLD = 1'b0,
        CFG_ARC_LENGTH     = 1'b1
    } t_cfg_idx;

    typedef logic [RESP_W-1:0] t_len;

    typedef struct packed {
        logic bright;
        logic dark;
    } t_class;

    // handshake-side control that travels with a stage-2 item into the merge
    typedef struct packed {
        logic valid;
        logic reject;
    } t_stage_ctl;

    function automatic t_len max4(input t_len a, input t_len b,
                                  input t_len c, input t_len d);
        t_len m_ab;
        t_len m_cd;
        m_ab = (a > b) ? a : b;
        m_cd = (c > d) ? c : d;
        return (m_ab > m_cd) ? m_ab : m_cd;
    endfunction

endpackage

// ===== src/fcar_class_lane.sv =====
// one neighbour classifier: brighter, darker or similar against the centre bounds
module fcar_class_lane (
    input  logic [fcar_pkg::PIX_W-1:0] i_pixel,
    input  logic [fcar_pkg::PIX_W:0]   i_hi,
    input  logic signed [fcar_pkg::PIX_W+1:0] i_lo,
    output fcar_pkg::t_class           o_class
);

    logic signed [fcar_pkg::PIX_W+1:0] w_pix_s;

    assign w_pix_s = $signed({2'b00, i_pixel});

    always_comb begin
        o_class.bright = ({1'b0, i_pixel} > i_hi);
        o_class.dark   = (w_pix_s < i_lo);
    end

endmodule

// ===== src/fcar_run_lane.sv =====
// run length starting at one ring position, going clockwise and wrapping
module fcar_run_lane #(
    parameter int LANE = 0
) (
    input  logic [fcar_pkg::RING_SIZE-1:0] i_bright,
    input  logic [fcar_pkg::RING_SIZE-1:0] i_dark,
    output fcar_pkg::t_len                 o_len
);

    localparam int N = fcar_pkg::RING_SIZE;

    logic [N-1:0]   w_mask;
    logic [2*N-1:0] w_dbl;
    logic [N-1:0]   w_rot;

    // a run starting here is of whichever class this position holds
    assign w_mask = i_bright[LANE] ? i_bright : i_dark;
    assign w_dbl  = {w_mask, w_mask};
    assign w_rot  = w_dbl[LANE +: N];

    // trailing ones; a full ring gives the ring size
    always_comb begin
        o_len = fcar_pkg::t_len'(N);
        for (int j = N - 1; j >= 0; j--) begin
            if (!w_rot[j]) begin
                o_len = fcar_pkg::t_len'(j);
            end
        end
    end

endmodule

// ===== src/fcar_merge.sv =====
// two-level registered maximum over the lane run lengths, precheck gating, output register
`include "fast_corner_arc_response_defines.svh"

module fcar_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcar_pkg::t_len        i_lane_len [fcar_pkg::RING_SIZE],
    input  fcar_pkg::t_stage_ctl  i_ctl,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [fcar_pkg::RESP_W-1:0] o_response
);

    localparam int NG = fcar_pkg::NUM_GROUPS;
    localparam int GS = fcar_pkg::GROUP_SIZE;

    logic           r_v3;
    logic           r_s3_reject;
    fcar_pkg::t_len r_s3_max [NG];
    logic           r_v4;
    fcar_pkg::t_len r_resp;

    logic           w_en3;
    logic           w_en4;
    fcar_pkg::t_len n_s3_max [NG];
    fcar_pkg::t_len n_resp;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;
    assign o_valid = r_v4;
    assign o_response = r_resp;

    // first level: maximum within each group of four lanes
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_s3_max[g] = fcar_pkg::max4(i_lane_len[g*GS], i_lane_len[g*GS+1],
                                         i_lane_len[g*GS+2], i_lane_len[g*GS+3]);
        end
    end

    // second level plus precheck reject
    always_comb begin
        n_resp = fcar_pkg::max4(r_s3_max[0], r_s3_max[1], r_s3_max[2], r_s3_max[3]);
        if (r_s3_reject) begin
            n_resp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_ctl.valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_reject <= i_ctl.reject;
            r_s3_max    <= n_s3_max;
        end
        if (w_en4) begin
            r_resp <= n_resp;
        end
    end

    `FCAR_ASSERT_IMP(a_resp_range, i_clk, i_rst_n, o_valid,
        o_response <= fcar_pkg::RING_SIZE[fcar_pkg::RESP_W-1:0], "response beyond ring size")
    `FCAR_ASSERT_NXT(a_reject_zero, i_clk, i_rst_n, r_v3 && w_en4 && r_s3_reject,
        o_valid && (o_response == '0), "rejected candidate gave non-zero response")
    `FCAR_ASSERT_NXT(a_stage_move, i_clk, i_rst_n, r_v3 && w_en4,
        o_valid, "merge stage item lost on its way to the output")

endmodule

// ===== src/fast_corner_arc_response.sv =====
// top level of the segment-test corner response pipeline
// One candidate pixel and its sixteen ring neighbours are taken per transfer,
// and one response per candidate leaves on the output channel in the same
// order. With the output side ready the block takes a new candidate every
// clock; there are four stage registers, the last of which drives output
// valid. Stage 1
// runs sixteen classifier lanes against the centre +/- threshold bounds and
// the compass precheck on neighbours 0, 4, 8 and 12 (enabled when the arc
// length register is 12 or more). Stage 2 runs sixteen run-length lanes, each
// finding the clockwise brighter or darker run starting at its own position
// with wrap-around. Stages 3 and 4 merge the lane results through a two-level
// maximum tree into the output register, forcing zero when the precheck
// failed. Each stage advances independently, so bubbles close up and a held
// output stalls only as far back as needed. Configuration writes take effect
// at once and should only be made while the pipeline is empty.
module fast_corner_arc_response (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [fcar_pkg::PIX_W-1:0]       i_centre_pixel,
    input  logic [fcar_pkg::RING_SIZE*4-1:0] i_ring_first_half,
    input  logic [fcar_pkg::RING_SIZE*4-1:0] i_ring_second_half,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [fcar_pkg::RESP_W-1:0]      o_response,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [fcar_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int N  = fcar_pkg::RING_SIZE;
    localparam int PW = fcar_pkg::PIX_W;

    // configuration registers
    logic [fcar_pkg::THR_W-1:0] r_diff_threshold;
    logic [fcar_pkg::ARC_W-1:0] r_arc_length;

    // stage 1: class bits and precheck verdict
    logic         r_v1;
    logic [N-1:0] r_s1_bright;
    logic [N-1:0] r_s1_dark;
    logic         r_s1_reject;

    // stage 2: per-lane run lengths
    logic           r_v2;
    fcar_pkg::t_len r_s2_len [N];
    logic           r_s2_reject;

    logic [N*PW-1:0]     w_ring;
    logic [PW:0]         w_hi;
    logic signed [PW+1:0] w_lo;
    fcar_pkg::t_class    w_class [N];
    logic [N-1:0]        n_s1_bright;
    logic [N-1:0]        n_s1_dark;
    logic [2:0]          w_nb;
    logic [2:0]          w_nd;
    logic                n_s1_reject;
    fcar_pkg::t_len      w_lane_len [N];
    logic                w_en1;
    logic                w_en2;
    logic                w_merge_ready;
    fcar_pkg::t_stage_ctl w_s2_ctl;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_threshold <= fcar_pkg::THR_RESET;
            r_arc_length     <= fcar_pkg::ARC_RESET;
        end else if (i_cfg_we) begin
            unique case (fcar_pkg::t_cfg_idx'(i_cfg_index))
                fcar_pkg::CFG_DIFF_THRESHOLD: r_diff_threshold <= i_cfg_wdata;
                fcar_pkg::CFG_ARC_LENGTH:
                    r_arc_length <= i_cfg_wdata[fcar_pkg::ARC_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // stage advance: each stage moves when empty or when the next one moves
    // ---------------------------------------------------------------------
    assign w_en2   = !r_v2 || w_merge_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // ---------------------------------------------------------------------
    // stage 1: classifier lanes
    // ---------------------------------------------------------------------
    assign w_ring = {i_ring_second_half, i_ring_first_half};

    // upper bound never wraps; lower bound may go negative, leaving darker empty
    assign w_hi = {1'b0, i_centre_pixel} + {1'b0, r_diff_threshold};
    assign w_lo = $signed({2'b00, i_centre_pixel}) - $signed({2'b00, r_diff_threshold});

    for (genvar k = 0; k < N; k++) begin : g_class
        fcar_class_lane u_class (
            .i_pixel (w_ring[k*PW +: PW]),
            .i_hi    (w_hi),
            .i_lo    (w_lo),
            .o_class (w_class[k])
        );
        assign n_s1_bright[k] = w_class[k].bright;
        assign n_s1_dark[k]   = w_class[k].dark;
    end

    // compass precheck: three of the four compass points must agree
    always_comb begin
        w_nb = '0;
        w_nd = '0;
        for (int c = 0; c < N; c += fcar_pkg::COMPASS_STEP) begin
            w_nb = w_nb + {2'b00, n_s1_bright[c]};
            w_nd = w_nd + {2'b00, n_s1_dark[c]};
        end
        n_s1_reject = (r_arc_length >= fcar_pkg::PRECHECK_MIN_ARC)
                   && (w_nb < fcar_pkg::PRECHECK_AGREE)
                   && (w_nd < fcar_pkg::PRECHECK_AGREE);
    end

    // ---------------------------------------------------------------------
    // stage 2: run-length lanes
    // ---------------------------------------------------------------------
    for (genvar k = 0; k < N; k++) begin : g_run
        fcar_run_lane #(
            .LANE (k)
        ) u_run (
            .i_bright (r_s1_bright),
            .i_dark   (r_s1_dark),
            .o_len    (w_lane_len[k])
        );
    end

    // ---------------------------------------------------------------------
    // stage registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_bright <= n_s1_bright;
            r_s1_dark   <= n_s1_dark;
            r_s1_reject <= n_s1_reject;
        end
        if (w_en2) begin
            r_s2_len    <= w_lane_len;
            r_s2_reject <= r_s1_reject;
        end
    end

    // ---------------------------------------------------------------------
    // stages 3 and 4: maximum tree and output register
    // ---------------------------------------------------------------------
    always_comb begin
        w_s2_ctl.valid  = r_v2;
        w_s2_ctl.reject = r_s2_reject;
    end

    fcar_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane_len (r_s2_len),
        .i_ctl      (w_s2_ctl),
        .o_ready    (w_merge_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_response (o_response)
    );

endmodule
